// ----- hw/rtl/stcd_pkg.sv -----
// stcd_pkg: types, field widths and result codes shared by the sorted table
// with category drain (cells, top level and checker)
// no dependencies
`default_nettype none

package stcd_pkg;

  // default sizing of the table
  localparam int unsigned DEF_CAPACITY       = 32;
  localparam int unsigned DEF_NUM_CATEGORIES = 6;

  // field widths
  localparam int unsigned KEY_W  = 16;
  localparam int unsigned CAT_W  = 3;
  localparam int unsigned YEAR_W = 12;
  localparam int unsigned ST_W   = 3;

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_DRAINED   = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTHING   = 3'd4;

  // input item
  typedef struct packed {
    logic              opcode;
    logic [KEY_W-1:0]  entry_key;
    logic [CAT_W-1:0]  entry_category;
    logic [YEAR_W-1:0] entry_year;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [CAT_W-1:0]  out_category;
    logic [KEY_W-1:0]  out_key;
    logic [YEAR_W-1:0] out_year;
    logic              last;
  } out_item_t;

  // one stored table entry
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CAT_W-1:0]  cat;
    logic [YEAR_W-1:0] year;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic   insert_en;
    logic   rotate_en;
    entry_t new_entry;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/stcd_cell.sv -----
// stcd_cell: one slot of the sorted chain; compares its key with the new
// item, shifts right on insert and rotates left during a drain
// depends on stcd_pkg
`default_nettype none

module stcd_cell
  import stcd_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  parameter int unsigned IDX      = 0
) (
  input  wire logic                          clk,
  input  wire cell_cmd_t                     cmd,
  input  wire logic [$clog2(CAPACITY+1)-1:0] cnt,
  input  wire entry_t                        left_entry,
  input  wire logic                          left_lt,
  input  wire entry_t                        right_entry,
  input  wire entry_t                        head_entry,
  output entry_t                             entry,
  output logic                               lt,
  output logic                               eq
);

  localparam int unsigned CNT_W = $clog2(CAPACITY+1);

  entry_t entry_r;
  entry_t entry_nxt;
  logic   in_use;
  logic   is_tail;

  // slot occupancy and position of the tail of the occupied run
  assign in_use  = CNT_W'(IDX) < cnt;
  assign is_tail = (CNT_W'(IDX) + CNT_W'(1)) == cnt;

  // key compares against the item being inserted
  assign lt = in_use && (entry_r.key < cmd.new_entry.key);
  assign eq = in_use && (entry_r.key == cmd.new_entry.key);

  // next slot content
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.insert_en) begin
      if (lt) begin
        entry_nxt = entry_r;
      end else if (left_lt) begin
        entry_nxt = cmd.new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (cmd.rotate_en) begin
      entry_nxt = is_tail ? head_entry : right_entry;
    end
  end

  // slot storage, no reset needed
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_table_category_drain.sv -----
// sorted_table_category_drain: top level, a chain of stcd_cell slots kept in
// ascending key order plus the insert and drain control
// depends on stcd_pkg and stcd_cell
//
//  channel | ports                      | handshake
//  --------+----------------------------+---------------------------------
//  input   | start, busy, in_item       | taken when start high, busy low
//  result  | out_valid, out_item        | one-cycle strobe, never stalled
//
// an insert's result strobes the cycle after the item is taken and busy
// stays low, so inserts can follow each other every cycle.
// a drain holds busy high while the chain rotates one slot per cycle; each
// full rotation scans one category, and the drain ends on the cycle of its
// last item.
// an empty-table drain gives its single result the cycle after it is taken.
// reset (rst_n low, synchronous) empties the table; the receiver never stalls.
`default_nettype none

module sorted_table_category_drain
  import stcd_pkg::*;
#(
  parameter int unsigned CAPACITY       = DEF_CAPACITY,
  parameter int unsigned NUM_CATEGORIES = DEF_NUM_CATEGORIES
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int unsigned CNT_W = $clog2(CAPACITY+1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CAT_W-1:0] CAT_MAX = CAT_W'(NUM_CATEGORIES - 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_DRAIN = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CAT_W-1:0]   cat_r, cat_nxt;
  logic [IDX_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]   emitted_r, emitted_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  cell_cmd_t          cmd;
  entry_t             cell_entry [CAPACITY];
  entry_t             left_e     [CAPACITY];
  entry_t             right_e    [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] left_lt;

  logic               accept;
  logic               dup;
  logic               full;
  logic               head_hit;
  logic               head_last;
  logic               step_end;
  entry_t             sat_entry;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r == S_DRAIN);

  // new entry with category saturated into range
  always_comb begin
    sat_entry.key  = in_item.entry_key;
    sat_entry.year = in_item.entry_year;
    sat_entry.cat  = (in_item.entry_category > CAT_MAX) ? CAT_MAX : in_item.entry_category;
  end

  assign dup  = |eq_vec;
  assign full = (cnt_r == CNT_W'(CAPACITY));

  // commands to the chain
  always_comb begin
    cmd.new_entry = sat_entry;
    cmd.insert_en = accept && (in_item.opcode == OP_INSERT) && !dup && !full;
    cmd.rotate_en = (state_r == S_DRAIN);
  end

  // neighbour wiring of the chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_wire
    if (i == 0) begin : g_first
      assign left_e[i]  = sat_entry;
      assign left_lt[i] = 1'b1;
    end else begin : g_mid
      assign left_e[i]  = cell_entry[i-1];
      assign left_lt[i] = lt_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e[i] = cell_entry[0];
    end else begin : g_inner
      assign right_e[i] = cell_entry[i+1];
    end

    stcd_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .cnt         (cnt_r),
      .left_entry  (left_e[i]),
      .left_lt     (left_lt[i]),
      .right_entry (right_e[i]),
      .head_entry  (cell_entry[0]),
      .entry       (cell_entry[i]),
      .lt          (lt_vec[i]),
      .eq          (eq_vec[i])
    );
  end

  // drain bookkeeping at the head of the chain
  assign head_hit  = (cell_entry[0].cat == cat_r);
  assign head_last = (emitted_r + CNT_W'(1)) == cnt_r;
  assign step_end  = (CNT_W'(step_r) + CNT_W'(1)) == cnt_r;

  // control and result next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cat_nxt       = cat_r;
    step_nxt      = step_r;
    emitted_nxt   = emitted_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.last  = 1'b1;
          if (in_item.opcode == OP_INSERT) begin
            priority if (dup) begin
              out_nxt.status = ST_DUPLICATE;
            end else if (full) begin
              out_nxt.status = ST_FULL;
            end else begin
              out_nxt.status = ST_INSERTED;
              cnt_nxt        = cnt_r + CNT_W'(1);
            end
          end else if (cnt_r == '0) begin
            out_nxt.status = ST_NOTHING;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = S_DRAIN;
            cat_nxt       = '0;
            step_nxt      = '0;
            emitted_nxt   = '0;
          end
        end
      end
      S_DRAIN: begin
        // emit the head slot when it belongs to the category being scanned
        if (head_hit) begin
          out_valid_nxt        = 1'b1;
          out_nxt.status       = ST_DRAINED;
          out_nxt.out_category = cell_entry[0].cat;
          out_nxt.out_key      = cell_entry[0].key;
          out_nxt.out_year     = cell_entry[0].year;
          out_nxt.last         = head_last;
          emitted_nxt          = emitted_r + CNT_W'(1);
        end
        if (head_hit && head_last) begin
          state_nxt = S_IDLE;
          cnt_nxt   = '0;
        end else if (step_end) begin
          step_nxt = '0;
          cat_nxt  = cat_r + CAT_W'(1);
        end else begin
          step_nxt = step_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cat_r       <= '0;
      step_r      <= '0;
      emitted_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cat_r       <= cat_nxt;
      step_r      <= step_nxt;
      emitted_r   <= emitted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

// ----- hw/rtl/stcd_checker.sv -----
// stcd_checker: port-level checks of the sorted table with category drain,
// bound to the top level
// depends on stcd_pkg and sorted_table_category_drain
`default_nettype none

module stcd_checker
  import stcd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire out_item_t out_item
);

  // an insert item answers on the next cycle with a single marked result
  a_insert_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.opcode == OP_INSERT) |=> (out_valid && out_item.last))
    else $error("insert item without its result");

  // every result other than a drained entry is the only one of its item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_DRAINED) |-> out_item.last)
    else $error("non-drain result not marked last");

  // a drained entry that is not the last keeps the block busy
  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_DRAINED && !out_item.last) |-> busy)
    else $error("drain ended before its last item");

  // a drain ends exactly with its last drained item
  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |->
      (out_valid && out_item.last && out_item.status == ST_DRAINED))
    else $error("drain ended without a last drained item");

endmodule

bind sorted_table_category_drain stcd_checker u_stcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

// ----- bench/tb.sv -----
// tb: self-checking bench for sorted_table_category_drain (sorted insert, category drain)
// drives a directed table then random fill/drain runs, predicts results with a shadow table
// depends on stcd_pkg and the sorted_table_category_drain rtl
`default_nettype none

module tb
  import stcd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_CAP     = DEF_CAPACITY;
  localparam int TBL_CATS    = DEF_NUM_CATEGORIES;
  localparam int TOTAL_ITEMS = 370;
  localparam int CALM_TAIL   = 50;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // shadow copy of the table
  entry_t    shadow [TBL_CAP];
  int        shadow_count;

  out_item_t pending_results [$];
  dir_row_t  dir_rows [$];
  bit        row_typed;
  out_item_t row_res;

  int        taken_count;
  int        sent;
  int        idle_pct;
  int        checked;
  int        mismatches;
  int        tally [8];
  int        empty_drains;

  sorted_table_category_drain dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result for an insert or an empty drain: status only, last set
  function automatic out_item_t status_only(input logic [ST_W-1:0] st);
    out_item_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  // apply one item to the shadow table and queue the results it causes
  task automatic table_step(input in_item_t it);
    int               pos;
    int               i;
    int               c;
    int               n;
    logic [CAT_W-1:0] cat;
    out_item_t        r;
    if (it.opcode == OP_INSERT) begin
      r   = status_only(ST_INSERTED);
      pos = 0;
      while (pos < shadow_count && shadow[pos].key < it.entry_key) pos++;
      // key compare wins over the space check
      if (pos < shadow_count && shadow[pos].key == it.entry_key) begin
        r.status = ST_DUPLICATE;
      end else if (shadow_count >= TBL_CAP) begin
        r.status = ST_FULL;
      end else begin
        for (i = shadow_count; i > pos; i--) shadow[i] = shadow[i-1];
        // out-of-range category saturates to the top bucket
        cat = (it.entry_category >= TBL_CATS) ? CAT_W'(TBL_CATS - 1) : it.entry_category;
        shadow[pos].key  = it.entry_key;
        shadow[pos].cat  = cat;
        shadow[pos].year = it.entry_year;
        shadow_count++;
      end
      tally[r.status]++;
      pending_results.push_back(r);
    end else if (shadow_count == 0) begin
      empty_drains++;
      pending_results.push_back(status_only(ST_NOTHING));
    end else begin
      // one pass per category, ascending keys within it
      n = 0;
      for (c = 0; c < TBL_CATS; c++) begin
        for (i = 0; i < shadow_count; i++) begin
          if (shadow[i].cat == c) begin
            r.status       = ST_DRAINED;
            r.out_category = shadow[i].cat;
            r.out_key      = shadow[i].key;
            r.out_year     = shadow[i].year;
            r.last         = (n + 1 == shadow_count);
            pending_results.push_back(r);
            tally[ST_DRAINED]++;
            n++;
          end
        end
      end
      shadow_count = 0;
    end
  endtask

  // take items, predict, and check results against the oldest expectation
  always @(posedge clk) begin
    out_item_t e;
    int        n0;
    bit        bad;
    if (rst_n) begin
      if (out_valid) begin
        checked++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("tb: unexpected result st=%0d cat=%0d key=%h year=%h last=%b",
                     out_item.status, out_item.out_category, out_item.out_key,
                     out_item.out_year, out_item.last);
        end else begin
          e   = pending_results.pop_front();
          bad = (out_item.status !== e.status) ||
                (out_item.out_category !== e.out_category) ||
                (out_item.out_key !== e.out_key) ||
                (out_item.out_year !== e.out_year) ||
                (out_item.last !== e.last);
          if (bad) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("tb: mismatch exp st=%0d cat=%0d key=%h year=%h last=%b",
                       e.status, e.out_category, e.out_key, e.out_year, e.last);
              $display("tb:          got st=%0d cat=%0d key=%h year=%h last=%b",
                       out_item.status, out_item.out_category, out_item.out_key,
                       out_item.out_year, out_item.last);
            end
          end
        end
      end
      if (start && !busy) begin
        n0 = pending_results.size();
        table_step(in_item);
        // typed-in rows replace the predicted result
        if (row_typed) begin
          while (pending_results.size() > n0) void'(pending_results.pop_back());
          pending_results.push_back(row_res);
        end
        taken_count++;
      end
    end
  end

  // present one item from a falling edge and hold it until taken
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t res);
    int n;
    if (sent % 16 == 0) begin
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 25;
        default: idle_pct = 60;
      endcase
    end
    if (sent < TOTAL_ITEMS - CALM_TAIL && $urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    n         = taken_count;
    in_item   = it;
    row_typed = typed;
    row_res   = res;
    start     = 1'b1;
    while (taken_count == n) @(negedge clk);
    sent++;
  endtask

  task automatic add_row(input logic op, input logic [KEY_W-1:0] key,
                         input logic [CAT_W-1:0] cat, input logic [YEAR_W-1:0] year,
                         input bit typed, input logic [ST_W-1:0] st);
    dir_row_t d;
    d.it.opcode         = op;
    d.it.entry_key      = key;
    d.it.entry_category = cat;
    d.it.entry_year     = year;
    d.typed             = typed;
    d.res               = status_only(st);
    dir_rows.push_back(d);
  endtask

  initial begin
    in_item_t          it;
    logic [KEY_W-1:0]  used_keys [$];
    int                fill;
    int                i;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    row_typed    = 1'b0;
    row_res      = '0;
    shadow_count = 0;
    taken_count  = 0;
    sent         = 0;
    idle_pct     = 0;
    checked      = 0;
    mismatches   = 0;
    empty_drains = 0;
    foreach (tally[k]) tally[k] = 0;

    // directed rows: empty drain, key and year extremes, duplicates, saturation
    add_row(OP_DRAIN,  16'hFFFF, 3'd7, 12'hFFF, 1, ST_NOTHING);
    add_row(OP_INSERT, 16'h8000, 3'd0, 12'h000, 1, ST_INSERTED);
    add_row(OP_INSERT, 16'hFFFF, 3'd5, 12'hFFF, 1, ST_INSERTED);
    add_row(OP_INSERT, 16'h0000, 3'd7, 12'hABC, 1, ST_INSERTED);
    add_row(OP_INSERT, 16'hFFFF, 3'd2, 12'h001, 1, ST_DUPLICATE);
    add_row(OP_INSERT, 16'h0000, 3'd0, 12'h000, 1, ST_DUPLICATE);
    add_row(OP_INSERT, 16'h5555, 3'd6, 12'h555, 1, ST_INSERTED);
    add_row(OP_INSERT, 16'hAAAA, 3'd3, 12'hAAA, 1, ST_INSERTED);
    add_row(OP_INSERT, 16'h1234, 3'd1, 12'h7FF, 1, ST_INSERTED);
    add_row(OP_INSERT, 16'h7FFF, 3'd4, 12'h800, 1, ST_INSERTED);
    add_row(OP_INSERT, 16'h0001, 3'd0, 12'h001, 1, ST_INSERTED);
    add_row(OP_DRAIN,  16'h1234, 3'd3, 12'h5A5, 0, ST_DRAINED);
    add_row(OP_DRAIN,  16'h0000, 3'd0, 12'h000, 1, ST_NOTHING);
    add_row(OP_INSERT, 16'h4000, 3'd2, 12'h007, 1, ST_INSERTED);
    add_row(OP_DRAIN,  16'hFFFF, 3'd5, 12'hFFF, 0, ST_DRAINED);
    add_row(OP_INSERT, 16'hFFFE, 3'd5, 12'h0F0, 1, ST_INSERTED);
    add_row(OP_INSERT, 16'h0002, 3'd5, 12'hF0F, 1, ST_INSERTED);
    add_row(OP_INSERT, 16'h0003, 3'd7, 12'h123, 1, ST_INSERTED);
    add_row(OP_DRAIN,  16'h0000, 3'd0, 12'h000, 0, ST_DRAINED);

    // synchronous reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].res);

    // random runs: a fill of random entries, then a drain
    while (sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1:    fill = $urandom_range(30, 40);
        2:       fill = 0;
        default: fill = $urandom_range(1, 12);
      endcase
      used_keys.delete();
      for (i = 0; i < fill; i++) begin
        it.opcode = OP_INSERT;
        if (used_keys.size() != 0 && $urandom_range(0, 7) == 0)
          it.entry_key = used_keys[$urandom_range(0, used_keys.size() - 1)];
        else
          it.entry_key = KEY_W'($urandom);
        used_keys.push_back(it.entry_key);
        it.entry_category = CAT_W'($urandom_range(0, 7));
        it.entry_year     = YEAR_W'($urandom);
        send_item(it, 1'b0, '0);
      end
      // drain fields carry junk, they must be ignored
      it.opcode         = OP_DRAIN;
      it.entry_key      = KEY_W'($urandom);
      it.entry_category = CAT_W'($urandom);
      it.entry_year     = YEAR_W'($urandom);
      send_item(it, 1'b0, '0);
    end
    start = 1'b0;

    // drain out, then allow for a full-table drain worth of stray results
    wait (pending_results.size() == 0);
    repeat (TBL_CAP * TBL_CATS + 20) @(posedge clk);

    $display("tb: %0d items sent: %0d inserted, %0d duplicates, %0d refused as full",
             sent, tally[ST_INSERTED], tally[ST_DUPLICATE], tally[ST_FULL]);
    $display("tb: %0d entries drained, %0d empty drains, %0d results checked, %0d mismatches",
             tally[ST_DRAINED], empty_drains, checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

`default_nettype wire
